// ----- hw/rtl/in_order_completion_reorder_macros.svh -----
// ----------------------------------------------------------------------------
// in_order_completion_reorder assertion macros
// shared concurrent assertion forms, sampled on clk, quiet during reset
// ----------------------------------------------------------------------------
`ifndef IN_ORDER_COMPLETION_REORDER_MACROS_SVH
`define IN_ORDER_COMPLETION_REORDER_MACROS_SVH

// same-cycle implication
`define IOCR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IOCR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/iocr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iocr_pkg
// shared constants, state encoding and controller/datapath interface types
// ----------------------------------------------------------------------------
package iocr_pkg;

    localparam int SLOTS_DEF  = 64;
    localparam int MAX_RUN    = 64;
    localparam int RUN_W      = $clog2(MAX_RUN + 1);

    localparam int FNUM_W     = 32;
    localparam int HANDLE_W   = 16;
    localparam int BYTES_W    = 24;
    localparam int TS_W       = 64;
    localparam int CNT_W      = 32;
    localparam int DESC_W     = HANDLE_W + BYTES_W + TS_W;

    localparam int IN_RAW_W   = FNUM_W + DESC_W;
    localparam int IN_DATA_W  = ((IN_RAW_W + 7) / 8) * 8;
    localparam int OUT_RAW_W  = FNUM_W + DESC_W + 2 * CNT_W;
    localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

    // slot index remainder is built this many sequence bits per cycle
    localparam int MOD_BITS   = 4;
    localparam int MOD_STEPS  = FNUM_W / MOD_BITS;
    localparam int MOD_CNT_W  = $clog2(MOD_STEPS);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_WRITE,
        ST_READ,
        ST_CHECK,
        ST_STATUS
    } state_t;

    typedef struct packed {
        logic cap;
        logic cnt_drop;
        logic mod_step;
        logic store;
        logic take;
        logic push_hold;
        logic push_final;
        logic clr_step;
    } cmd_t;

    typedef struct packed {
        logic in_ok;
        logic slot_rdy;
        logic run_full;
        logic hold_valid;
        logic out_free;
        logic sweep_last;
        logic mod_last;
    } sts_t;

endpackage

// ----- hw/rtl/iocr_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iocr_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module iocr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/iocr_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iocr_ctrl
// sequencer: clearing pass, report intake, slot write and in-order drain
// ----------------------------------------------------------------------------
module iocr_ctrl #(
    parameter int SLOTS = iocr_pkg::SLOTS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  iocr_pkg::sts_t  sts,
    output iocr_pkg::cmd_t  cmd
);

    localparam bit IS_POW2 = (SLOTS & (SLOTS - 1)) == 0;

    iocr_pkg::state_t state_reg;
    iocr_pkg::state_t state_next;
    logic             can_take;

    assign can_take = sts.slot_rdy && !sts.run_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= iocr_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            iocr_pkg::ST_CLEAR:
            begin
                if (sts.sweep_last)
                begin
                    state_next = iocr_pkg::ST_IDLE;
                end
            end
            iocr_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (!sts.in_ok)
                    begin
                        state_next = iocr_pkg::ST_STATUS;
                    end
                    else if (IS_POW2)
                    begin
                        state_next = iocr_pkg::ST_WRITE;
                    end
                    else
                    begin
                        state_next = iocr_pkg::ST_MOD;
                    end
                end
            end
            iocr_pkg::ST_MOD:
            begin
                if (sts.mod_last)
                begin
                    state_next = iocr_pkg::ST_WRITE;
                end
            end
            iocr_pkg::ST_WRITE:
            begin
                state_next = iocr_pkg::ST_READ;
            end
            iocr_pkg::ST_READ:
            begin
                state_next = iocr_pkg::ST_CHECK;
            end
            iocr_pkg::ST_CHECK:
            begin
                if (can_take)
                begin
                    if (!sts.hold_valid || sts.out_free)
                    begin
                        state_next = iocr_pkg::ST_READ;
                    end
                end
                else if (sts.out_free)
                begin
                    state_next = iocr_pkg::ST_IDLE;
                end
            end
            iocr_pkg::ST_STATUS:
            begin
                if (sts.out_free)
                begin
                    state_next = iocr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = iocr_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            iocr_pkg::ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
            end
            iocr_pkg::ST_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.cap      = in_valid;
                cmd.cnt_drop = in_valid && !sts.in_ok;
            end
            iocr_pkg::ST_MOD:
            begin
                cmd.mod_step = 1'b1;
            end
            iocr_pkg::ST_WRITE:
            begin
                cmd.store = 1'b1;
            end
            iocr_pkg::ST_READ:
            begin
                cmd = '0;
            end
            iocr_pkg::ST_CHECK:
            begin
                if (can_take)
                begin
                    // the held frame is not last: another one follows it
                    cmd.take      = !sts.hold_valid || sts.out_free;
                    cmd.push_hold = sts.hold_valid && sts.out_free;
                end
                else
                begin
                    cmd.push_final = sts.out_free;
                end
            end
            iocr_pkg::ST_STATUS:
            begin
                cmd.push_final = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ----- hw/rtl/iocr_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iocr_dp
// datapath: report capture, slot index remainder, slot memory, release
// pointer, counters, held frame and output register
// ----------------------------------------------------------------------------
`include "in_order_completion_reorder_macros.svh"

module iocr_dp #(
    parameter int SLOTS = iocr_pkg::SLOTS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [iocr_pkg::IN_DATA_W-1:0]    s_tdata,
    input  logic [0:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [iocr_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic [0:0]                        m_tuser,
    output logic                              m_tlast,
    input  iocr_pkg::cmd_t                    cmd,
    output iocr_pkg::sts_t                    sts
);

    localparam int                IDX_W     = $clog2(SLOTS);
    localparam bit                IS_POW2   = (SLOTS & (SLOTS - 1)) == 0;
    localparam logic [IDX_W-1:0]  IDX_MAX   = IDX_W'(SLOTS - 1);
    localparam logic [IDX_W:0]    SLOTS_EXT = (IDX_W + 1)'(SLOTS);
    localparam int                MEM_W     = iocr_pkg::DESC_W + 1;

    logic [iocr_pkg::FNUM_W-1:0]    fnum_reg;
    logic [iocr_pkg::DESC_W-1:0]    desc_reg;
    logic [iocr_pkg::FNUM_W-1:0]    shift_reg;
    logic [IDX_W-1:0]               rem_reg;
    logic [iocr_pkg::MOD_CNT_W-1:0] mod_cnt_reg;
    logic [iocr_pkg::FNUM_W-1:0]    next_release_reg;
    logic [IDX_W-1:0]               release_idx_reg;
    logic [iocr_pkg::CNT_W-1:0]     completed_reg;
    logic [iocr_pkg::CNT_W-1:0]     dropped_reg;
    logic [iocr_pkg::RUN_W-1:0]     run_cnt_reg;
    logic                           hold_valid_reg;
    logic [iocr_pkg::FNUM_W-1:0]    hold_fnum_reg;
    logic [iocr_pkg::DESC_W-1:0]    hold_desc_reg;
    logic                           out_valid_reg;
    logic [iocr_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic                           out_user_reg;
    logic                           out_last_reg;

    logic [IDX_W-1:0]               rem_acc;
    logic [IDX_W:0]                 trial;
    logic [IDX_W-1:0]               slot_idx;
    logic [IDX_W-1:0]               idx_inc;
    logic                           out_free;
    logic                           mem_wr_en;
    logic [IDX_W-1:0]               mem_wr_addr;
    logic [MEM_W-1:0]               mem_wr_data;
    logic [MEM_W-1:0]               mem_rd_data;

    // remainder of the sequence number by SLOTS, a few bits per step
    always_comb
    begin
        rem_acc = rem_reg;
        trial   = '0;
        for (int i = 0; i < iocr_pkg::MOD_BITS; i++)
        begin
            trial = {rem_acc, shift_reg[iocr_pkg::FNUM_W-1-i]};
            if (trial >= SLOTS_EXT)
            begin
                trial = trial - SLOTS_EXT;
            end
            rem_acc = trial[IDX_W-1:0];
        end
    end

    assign slot_idx = IS_POW2 ? fnum_reg[IDX_W-1:0] : rem_reg;
    assign idx_inc  = (release_idx_reg == IDX_MAX) ? '0 : release_idx_reg + 1'b1;
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            fnum_reg  <= s_tdata[iocr_pkg::FNUM_W-1:0];
            desc_reg  <= s_tdata[iocr_pkg::FNUM_W +: iocr_pkg::DESC_W];
            shift_reg <= s_tdata[iocr_pkg::FNUM_W-1:0];
        end
        else if (cmd.mod_step)
        begin
            shift_reg <= shift_reg << iocr_pkg::MOD_BITS;
        end
        if (cmd.cap)
        begin
            rem_reg <= '0;
        end
        else if (cmd.mod_step)
        begin
            rem_reg <= rem_acc;
        end
        if (cmd.take)
        begin
            hold_fnum_reg <= next_release_reg;
            hold_desc_reg <= mem_rd_data[iocr_pkg::DESC_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_cnt_reg      <= '0;
            next_release_reg <= '0;
            release_idx_reg  <= '0;
            completed_reg    <= '0;
            dropped_reg      <= '0;
            run_cnt_reg      <= '0;
            hold_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.cap)
            begin
                mod_cnt_reg <= '0;
            end
            else if (cmd.mod_step)
            begin
                mod_cnt_reg <= mod_cnt_reg + 1'b1;
            end
            if (cmd.cnt_drop)
            begin
                dropped_reg <= dropped_reg + 1'b1;
            end
            if (cmd.store)
            begin
                completed_reg  <= completed_reg + 1'b1;
                run_cnt_reg    <= '0;
                hold_valid_reg <= 1'b0;
            end
            else if (cmd.take)
            begin
                run_cnt_reg    <= run_cnt_reg + 1'b1;
                hold_valid_reg <= 1'b1;
            end
            else if (cmd.push_final)
            begin
                hold_valid_reg <= 1'b0;
            end
            if (cmd.take)
            begin
                next_release_reg <= next_release_reg + 1'b1;
                // the sequence wrap restarts the slot index at zero
                release_idx_reg  <= (next_release_reg == '1) ? '0 : idx_inc;
            end
            else if (cmd.clr_step)
            begin
                release_idx_reg <= idx_inc;
            end
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.push_hold)
        begin
            out_data_reg <= iocr_pkg::OUT_DATA_W'({dropped_reg, completed_reg,
                                                  hold_desc_reg, hold_fnum_reg});
            out_user_reg <= 1'b1;
            out_last_reg <= 1'b0;
        end
        else if (cmd.push_final)
        begin
            if (hold_valid_reg)
            begin
                out_data_reg <= iocr_pkg::OUT_DATA_W'({dropped_reg, completed_reg,
                                                      hold_desc_reg, hold_fnum_reg});
                out_user_reg <= 1'b1;
            end
            else
            begin
                out_data_reg <= iocr_pkg::OUT_DATA_W'({dropped_reg, completed_reg,
                                                      iocr_pkg::DESC_W'(0),
                                                      iocr_pkg::FNUM_W'(0)});
                out_user_reg <= 1'b0;
            end
            out_last_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.push_hold || cmd.push_final)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // slot memory: ready bit on top of the descriptor
    assign mem_wr_en   = cmd.store || cmd.take || cmd.clr_step;
    assign mem_wr_addr = cmd.store ? slot_idx : release_idx_reg;
    assign mem_wr_data = cmd.store ? {1'b1, desc_reg} : '0;

    iocr_ram #(
        .WIDTH (MEM_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (release_idx_reg),
        .rd_data (mem_rd_data)
    );

    always_comb
    begin
        sts.in_ok      = s_tuser[0];
        sts.slot_rdy   = mem_rd_data[iocr_pkg::DESC_W];
        sts.run_full   = run_cnt_reg == iocr_pkg::RUN_W'(iocr_pkg::MAX_RUN);
        sts.hold_valid = hold_valid_reg;
        sts.out_free   = out_free;
        sts.sweep_last = release_idx_reg == IDX_MAX;
        sts.mod_last   = mod_cnt_reg == iocr_pkg::MOD_CNT_W'(iocr_pkg::MOD_STEPS - 1);
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_user_reg;
    assign m_tlast    = out_last_reg;

    `IOCR_ASSERT_IMP(a_one_writer, cmd.take, !cmd.store && !cmd.clr_step,
                     "slot memory write port claimed twice")
    `IOCR_ASSERT_IMP(a_push_free, cmd.push_hold || cmd.push_final, out_free,
                     "result pushed into a full output register")
    `IOCR_ASSERT_NXT(a_read_bubble, cmd.take, !cmd.take,
                     "release taken without a fresh slot read")
    `IOCR_ASSERT_IMP(a_hold_replace, cmd.push_hold, cmd.take && hold_valid_reg,
                     "held frame sent without a successor")

endmodule

// ----- hw/rtl/in_order_completion_reorder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// in_order_completion_reorder
// reorder buffer that releases completed frame descriptors in sequence order
// ----------------------------------------------------------------------------
// Each input transaction is one completion report. A successful report stores
// its descriptor in slot (frame_number mod SLOTS), then frames are released in
// sequence order from the release pointer, up to 64 per report, each with
// tuser set; a failed report only bumps the drop counter. A report that
// releases nothing gives one status transaction with tuser clear. tlast marks
// the last transaction of a report, and every transaction carries both
// counters. After reset the whole slot memory is swept clear before the
// first report is taken. A failed report is captured and then pushes its
// status transaction. A successful one is captured, gets its slot index
// remainder when SLOTS is not a power of two, is written, and then needs one
// slot memory read and check per released frame, and waits while the output is stalled.
module in_order_completion_reorder #(
    parameter int SLOTS = iocr_pkg::SLOTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // frame_number, buffer_handle, byte_count, timestamp
    input  logic [iocr_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // encode_ok
    input  logic [0:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // out_frame_number, out_buffer_handle, out_byte_count, out_timestamp,
    // completed_total, dropped_total
    output logic [iocr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // frame_valid
    output logic [0:0]                      m_axis_tuser,
    output logic                            m_axis_tlast
);

    iocr_pkg::cmd_t cmd;
    iocr_pkg::sts_t sts;

    iocr_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    iocr_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_axis_tdata),
        .s_tuser  (s_axis_tuser),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_tdata  (m_axis_tdata),
        .m_tuser  (m_axis_tuser),
        .m_tlast  (m_axis_tlast),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule

// ----- tb/in_order_completion_reorder_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// in_order_completion_reorder_tb
// self-checking bench for the in-order completion reorder buffer
// ----------------------------------------------------------------------------
// Completion reports go in on the slave stream. A frame release tracker keeps
// its own copy of the slot memory, the release pointer and both counters, and
// queues the release transactions that each accepted report must produce.
// Every transaction on the master stream is checked field by field against
// the oldest queued one. A short directed run covers drops, out-of-order
// arrival, overwrites, aliased far-ahead and stale reports, and field
// extremes. The random run then sends shuffled windows of consecutive frames
// starting at the release pointer, with drops, overwrites and some noise
// mixed in, while both sides idle at random. One long receiver hold-off
// fills the block and stalls its input.
module in_order_completion_reorder_tb;
    import iocr_pkg::*;

    localparam int SLOTS           = SLOTS_DEF;
    localparam int CLK_HALF        = 10;
    localparam int RESET_CYCLES    = 4;
    localparam int IDLE_LIMIT      = 4000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int HOLD_OFF_AT     = 150;
    localparam int RANDOM_REPORTS  = 400;
    localparam int TAIL_CYCLES     = 40;

    // bit offsets inside tdata
    localparam int HANDLE_LSB = FNUM_W;
    localparam int BYTES_LSB  = HANDLE_LSB + HANDLE_W;
    localparam int TS_LSB     = BYTES_LSB + BYTES_W;
    localparam int DONE_LSB   = TS_LSB + TS_W;
    localparam int DROP_LSB   = DONE_LSB + CNT_W;

    typedef struct {
        logic [FNUM_W-1:0]   fnum;
        logic                ok;
        logic [HANDLE_W-1:0] handle;
        logic [BYTES_W-1:0]  bytes;
        logic [TS_W-1:0]     ts;
    } report_t;

    typedef struct {
        logic                frame_valid;
        logic [FNUM_W-1:0]   fnum;
        logic [HANDLE_W-1:0] handle;
        logic [BYTES_W-1:0]  bytes;
        logic [TS_W-1:0]     ts;
        logic                last;
        logic [CNT_W-1:0]    completed;
        logic [CNT_W-1:0]    dropped;
    } release_t;

    class frame_release_tracker;
        bit                  slot_ready [SLOTS];
        logic [HANDLE_W-1:0] slot_handle [SLOTS];
        logic [BYTES_W-1:0]  slot_bytes [SLOTS];
        logic [TS_W-1:0]     slot_ts [SLOTS];
        logic [FNUM_W-1:0]   next_release;
        logic [CNT_W-1:0]    completed_count;
        logic [CNT_W-1:0]    dropped_count;
        release_t            expected_q [$];
        int                  mismatches;

        function new();
            foreach (slot_ready[i])
                slot_ready[i] = 1'b0;
            next_release    = '0;
            completed_count = '0;
            dropped_count   = '0;
            mismatches      = 0;
        endfunction

        function int slot_of(logic [FNUM_W-1:0] fnum);
            return int'(fnum % FNUM_W'(SLOTS));
        endfunction

        // store the descriptor, then queue the in-order releases it unlocks
        function void note_report(report_t r);
            release_t rel;
            int       s;
            int       n;
            n = 0;
            if (r.ok)
            begin
                s = slot_of(r.fnum);
                slot_handle[s] = r.handle;
                slot_bytes[s]  = r.bytes;
                slot_ts[s]     = r.ts;
                slot_ready[s]  = 1'b1;
                completed_count++;
                while (n < MAX_RUN && slot_ready[slot_of(next_release)])
                begin
                    s = slot_of(next_release);
                    rel.frame_valid = 1'b1;
                    rel.fnum        = next_release;
                    rel.handle      = slot_handle[s];
                    rel.bytes       = slot_bytes[s];
                    rel.ts          = slot_ts[s];
                    rel.completed   = completed_count;
                    rel.dropped     = dropped_count;
                    slot_ready[s]   = 1'b0;
                    next_release++;
                    n++;
                    rel.last = (n == MAX_RUN) || !slot_ready[slot_of(next_release)];
                    expected_q.push_back(rel);
                end
            end
            else
            begin
                dropped_count++;
            end
            if (n == 0)
            begin
                rel.frame_valid = 1'b0;
                rel.fnum        = '0;
                rel.handle      = '0;
                rel.bytes       = '0;
                rel.ts          = '0;
                rel.last        = 1'b1;
                rel.completed   = completed_count;
                rel.dropped     = dropped_count;
                expected_q.push_back(rel);
            end
        endfunction

        function void compare_field(string field, logic [63:0] want, logic [63:0] seen);
            if (want !== seen)
            begin
                mismatches++;
                $error("%s: expected %0h, got %0h", field, want, seen);
            end
        endfunction

        function void check_release(release_t got);
            release_t want;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                $error("release transaction with nothing expected: frame %0h", got.fnum);
                return;
            end
            want = expected_q.pop_front();
            compare_field("frame_valid", want.frame_valid, got.frame_valid);
            compare_field("out_frame_number", want.fnum, got.fnum);
            compare_field("out_buffer_handle", want.handle, got.handle);
            compare_field("out_byte_count", want.bytes, got.bytes);
            compare_field("out_timestamp", want.ts, got.ts);
            compare_field("last_of_run", want.last, got.last);
            compare_field("completed_total", want.completed, got.completed);
            compare_field("dropped_total", want.dropped, got.dropped);
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [0:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [0:0]            m_axis_tuser;
    logic                  m_axis_tlast;

    frame_release_tracker tracker;
    release_t             observed;
    int                   reports_sent;
    int                   send_burst;
    int                   recv_burst;
    bit                   hold_off_done;
    int                   idle_cycles;

    in_order_completion_reorder #(
        .SLOTS (SLOTS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #CLK_HALF clk = ~clk;
    end

    // mostly short gaps, a few long ones, and now and then a burst with none
    function automatic int pick_gap(inout int burst);
        int roll;
        if (burst > 0)
        begin
            burst--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 2)
        begin
            burst = $urandom_range(20, 60);
            return 0;
        end
        if (roll < 35)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic report_t make_report(logic [FNUM_W-1:0] fnum, logic ok);
        report_t r;
        r.fnum   = fnum;
        r.ok     = ok;
        r.handle = HANDLE_W'($urandom);
        r.bytes  = BYTES_W'($urandom);
        r.ts     = {$urandom, $urandom};
        return r;
    endfunction

    task automatic send_report(input report_t r);
        int gap;
        gap = pick_gap(send_burst);
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = IN_DATA_W'({r.ts, r.bytes, r.handle, r.fnum});
        s_axis_tuser  = r.ok;
        do
            @(posedge clk);
        while (!s_axis_tready);
        tracker.note_report(r);
        reports_sent++;
    endtask

    // receiver side: random stalls plus one long hold-off partway through
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (!hold_off_done && reports_sent >= HOLD_OFF_AT)
            begin
                hold_off_done = 1'b1;
                stall = HOLD_OFF_CYCLES;
            end
            else
            begin
                stall = pick_gap(recv_burst);
            end
            if (stall > 0)
            begin
                @(negedge clk);
                m_axis_tready = 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            m_axis_tready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            observed.frame_valid = m_axis_tuser[0];
            observed.fnum        = m_axis_tdata[FNUM_W-1:0];
            observed.handle      = m_axis_tdata[HANDLE_LSB +: HANDLE_W];
            observed.bytes       = m_axis_tdata[BYTES_LSB +: BYTES_W];
            observed.ts          = m_axis_tdata[TS_LSB +: TS_W];
            observed.last        = m_axis_tlast;
            observed.completed   = m_axis_tdata[DONE_LSB +: CNT_W];
            observed.dropped     = m_axis_tdata[DROP_LSB +: CNT_W];
            tracker.check_release(observed);
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        report_t           r;
        logic [FNUM_W-1:0] frames [$];
        logic [FNUM_W-1:0] base;
        logic [FNUM_W-1:0] tmp;
        int                width;
        int                roll;
        int                j;
        int                last_idx;
        bit                first_window;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        reports_sent  = 0;
        send_burst    = 0;
        tracker       = new();
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // drop with nothing stored: status only
        send_report(make_report(32'd0, 1'b0));
        // ahead of the release pointer, all-zero descriptor
        r = make_report(32'd1, 1'b1);
        r.handle = '0;
        r.bytes  = '0;
        r.ts     = '0;
        send_report(r);
        // fills the gap with an all-ones descriptor, releases two frames
        r = make_report(32'd0, 1'b1);
        r.handle = '1;
        r.bytes  = '1;
        r.ts     = '1;
        send_report(r);
        send_report(make_report(32'd2, 1'b0));
        send_report(make_report(32'd3, 1'b1));
        send_report(make_report(32'd2, 1'b1));
        // far ahead, lands in the top slot
        send_report(make_report(32'hFFFF_FFFF, 1'b1));
        // aliases the slot of the pointer, released under the pointer's number
        send_report(make_report(32'd4 + FNUM_W'(SLOTS), 1'b1));
        // overwrite before release
        send_report(make_report(32'd6, 1'b1));
        send_report(make_report(32'd6, 1'b1));
        send_report(make_report(32'd5, 1'b1));
        send_report(make_report(32'h8000_0007, 1'b1));
        // stale report behind the pointer
        send_report(make_report(32'd3, 1'b1));
        send_report(make_report(32'hFFFF_FFFF, 1'b0));
        send_report(make_report(32'd8, 1'b1));

        first_window = 1'b1;
        while (reports_sent < RANDOM_REPORTS + 15)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 5)
            begin
                send_report(make_report($urandom, 1'($urandom_range(0, 1))));
            end
            else
            begin
                roll = $urandom_range(0, 99);
                if (first_window || roll >= 95)
                    width = MAX_RUN;
                else if (roll < 70)
                    width = $urandom_range(1, 8);
                else
                    width = $urandom_range(9, 32);
                first_window = 1'b0;
                base = tracker.next_release;
                frames.delete();
                for (int i = 0; i < width; i++)
                    frames.push_back(base + FNUM_W'(i));
                for (int i = width - 1; i > 0; i--)
                begin
                    j = $urandom_range(0, i);
                    tmp = frames[i];
                    frames[i] = frames[j];
                    frames[j] = tmp;
                end
                // sometimes hold back the head frame so one report drains all
                if (width == MAX_RUN || $urandom_range(0, 99) < 30)
                begin
                    last_idx = width - 1;
                    foreach (frames[i])
                        if (frames[i] == base)
                            j = i;
                    tmp = frames[last_idx];
                    frames[last_idx] = frames[j];
                    frames[j] = tmp;
                end
                foreach (frames[i])
                begin
                    if ($urandom_range(0, 99) < 12)
                        send_report(make_report(frames[i], 1'b0));
                    if ($urandom_range(0, 99) < 5)
                        send_report(make_report(frames[i], 1'b1));
                    send_report(make_report(frames[i], 1'b1));
                end
            end
        end

        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (tracker.expected_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (tracker.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
